// ===== rtl/linear_recurrence_matrix_power_defines.svh =====
// Assertion macros for the RTL of the recurrence block.
`ifndef LINEAR_RECURRENCE_MATRIX_POWER_DEFINES_SVH
`define LINEAR_RECURRENCE_MATRIX_POWER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LRMP_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LRMP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/lrmp_pkg.sv =====
// Types and constants of the linear recurrence matrix power block.
package lrmp_pkg;

  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int CELLS     = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int VAL_W     = 30;
  localparam int ORDER_W   = 5;
  localparam int N_W       = 63;

  localparam logic [VAL_W-1:0] MODULUS    = 30'd1000000000;
  // floor(2^60 / MODULUS)
  localparam logic [30:0]      BARRETT_MU = 31'd1152921504;

  typedef enum logic [1:0] {
    CMD_LOAD_COEF = 2'd0,
    CMD_LOAD_INIT = 2'd1,
    CMD_QUERY     = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMALL,
    ST_BUILD,
    ST_DECIDE,
    ST_PROD,
    ST_DRAIN,
    ST_COPY,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MD_PB,
    MD_SQ,
    MD_DOT
  } mode_e;

  // Tag that travels with one multiply-accumulate step.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              fin;
    logic [ADDR_W-1:0] addr;
  } mac_tag_t;

endpackage

// ===== rtl/lrmp_if.sv =====
// Handshake interfaces for the input and result channels.
interface lrmp_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [lrmp_pkg::IDX_W-1:0] slot;
  logic [lrmp_pkg::VAL_W-1:0] load_value;
  logic [lrmp_pkg::N_W-1:0]   term_index;

  modport source (output valid, command, slot, load_value, term_index, input ready);
  modport sink   (input valid, command, slot, load_value, term_index, output ready);
endinterface

interface lrmp_out_if;
  logic                      valid;
  logic                      ready;
  logic [lrmp_pkg::VAL_W-1:0] term_value;

  modport source (output valid, term_value, input ready);
  modport sink   (input valid, term_value, output ready);
endinterface

// ===== rtl/linear_recurrence_matrix_power.sv =====
// Top level: term n of an order-k linear recurrence mod 1e9 by matrix power.
//
//  port         dir  payload                                   role
//  in_i         in   command, slot, load_value, term_index     loads and queries
//  out_o        out  term_value                                one word per query
//  cfg_we_i     in   cfg_wdata_i (order)                       order register write
//
// A query with n <= k returns an initial value, or zero for n = 0. Otherwise the
// matrix products run on the one pipelined multiply-accumulate unit, which takes
// one step per cycle from the matrix RAMs. Reset sets order to 1 and needs no
// clearing pass. Input is taken only while idle; a finished word waits in the
// output register without blocking loads.
`include "linear_recurrence_matrix_power_defines.svh"

module linear_recurrence_matrix_power (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrmp_pkg::ORDER_W-1:0]  cfg_wdata_i,
  lrmp_in_if.sink                       in_i,
  lrmp_out_if.source                    out_o
);

  localparam int IW = lrmp_pkg::IDX_W;
  localparam int AW = lrmp_pkg::ADDR_W;
  localparam int VW = lrmp_pkg::VAL_W;

  lrmp_pkg::state_e state_q, state_d;
  lrmp_pkg::mode_e  mode_q, mode_d;

  logic [lrmp_pkg::ORDER_W-1:0] order_q;
  logic [IW-1:0] km1;
  logic [lrmp_pkg::ORDER_W-1:0] k_w;
  logic [lrmp_pkg::N_W-1:0] e_q, e_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, t_q, t_d;
  logic [VW-1:0] result_q, result_d, out_data_q, out_data_d;
  logic out_valid_q, out_valid_d;

  logic accept, is_query;
  logic [VW-1:0] load_val;
  logic j_last, i_last;
  logic mac_phase;

  lrmp_pkg::mac_tag_t tag_d, tag_q, mac_res;
  logic [VW-1:0] mac_a, mac_b, mac_val;

  logic bld_v_q, bld_v_d, bld_last_q, bld_last_d, bld_sup_q, bld_sup_d;
  logic bld_diag_q, bld_diag_d;
  logic [AW-1:0] bld_addr_q, bld_addr_d;
  logic cpy_v_q, cpy_v_d;
  logic [AW-1:0] cpy_addr_q, cpy_addr_d;

  logic coef_we, init_we;
  logic [IW-1:0] coef_raddr, init_raddr;
  logic [VW-1:0] coef_rd, init_rd, basea_rd, baseb_rd, power_rd, scratch_rd;
  logic base_we, power_we, scratch_we;
  logic [AW-1:0] mat_waddr;
  logic [VW-1:0] base_wdata, power_wdata;

  // Effective order: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    if (order_q == '0) begin
      km1 = '0;
    end else if (order_q > lrmp_pkg::ORDER_W'(lrmp_pkg::MAX_ORDER)) begin
      km1 = IW'(lrmp_pkg::MAX_ORDER - 1);
    end else begin
      km1 = IW'(order_q - 1'b1);
    end
    k_w = lrmp_pkg::ORDER_W'(km1) + 1'b1;
  end

  assign in_i.ready = (state_q == lrmp_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign is_query   = (in_i.command == lrmp_pkg::CMD_QUERY);
  assign load_val   = (in_i.load_value >= lrmp_pkg::MODULUS) ?
                      (in_i.load_value - lrmp_pkg::MODULUS) : in_i.load_value;
  assign coef_we    = accept && (in_i.command == lrmp_pkg::CMD_LOAD_COEF);
  assign init_we    = accept && (in_i.command == lrmp_pkg::CMD_LOAD_INIT);

  assign j_last = (mode_q == lrmp_pkg::MD_DOT) || (j_q == km1);
  assign i_last = (mode_q == lrmp_pkg::MD_DOT) || (i_q == km1);

  assign mac_phase = (state_q == lrmp_pkg::ST_PROD) || (state_q == lrmp_pkg::ST_DRAIN);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrmp_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          if (in_i.term_index == '0) begin
            state_d = lrmp_pkg::ST_DONE;
          end else if (in_i.term_index <= lrmp_pkg::N_W'(k_w)) begin
            state_d = lrmp_pkg::ST_SMALL;
          end else begin
            state_d = lrmp_pkg::ST_BUILD;
          end
        end
      end
      lrmp_pkg::ST_SMALL: state_d = lrmp_pkg::ST_DONE;
      lrmp_pkg::ST_BUILD: begin
        if (j_q == km1 && i_q == km1) begin
          state_d = lrmp_pkg::ST_DECIDE;
        end
      end
      lrmp_pkg::ST_DECIDE: begin
        if (e_q == '0 || e_q[0] || e_q[lrmp_pkg::N_W-1:1] != '0) begin
          state_d = lrmp_pkg::ST_PROD;
        end
      end
      lrmp_pkg::ST_PROD: begin
        if (t_q == km1 && j_last && i_last) begin
          state_d = lrmp_pkg::ST_DRAIN;
        end
      end
      lrmp_pkg::ST_DRAIN: begin
        if (mac_res.valid && mac_res.fin) begin
          state_d = (mode_q == lrmp_pkg::MD_DOT) ? lrmp_pkg::ST_DONE : lrmp_pkg::ST_COPY;
        end
      end
      lrmp_pkg::ST_COPY: begin
        if (j_q == km1 && i_q == km1) begin
          state_d = lrmp_pkg::ST_DECIDE;
        end
      end
      lrmp_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = lrmp_pkg::ST_IDLE;
        end
      end
      default: state_d = lrmp_pkg::ST_IDLE;
    endcase
  end

  // Counters, datapath control and output register.
  always_comb begin
    mode_d      = mode_q;
    e_d         = e_q;
    i_d         = i_q;
    j_d         = j_q;
    t_d         = t_q;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    tag_d       = '0;
    bld_v_d     = 1'b0;
    bld_addr_d  = {i_q, j_q};
    bld_last_d  = (i_q == km1);
    bld_sup_d   = ({1'b0, j_q} == {1'b0, i_q} + 1'b1);
    bld_diag_d  = (i_q == j_q);
    cpy_v_d     = 1'b0;
    cpy_addr_d  = {i_q, j_q};

    unique case (state_q)
      lrmp_pkg::ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        t_d = '0;
        if (accept && is_query) begin
          result_d = '0;
          e_d      = in_i.term_index - 1'b1;
        end
      end
      lrmp_pkg::ST_SMALL: result_d = init_rd;
      lrmp_pkg::ST_BUILD, lrmp_pkg::ST_COPY: begin
        if (state_q == lrmp_pkg::ST_BUILD) begin
          bld_v_d = 1'b1;
        end else begin
          cpy_v_d = 1'b1;
        end
        if (j_q == km1) begin
          j_d = '0;
          i_d = (i_q == km1) ? '0 : i_q + 1'b1;
          // drop the multiplied bit once the product is back in place
          if (i_q == km1 && state_q == lrmp_pkg::ST_COPY && mode_q == lrmp_pkg::MD_PB) begin
            e_d[0] = 1'b0;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      lrmp_pkg::ST_DECIDE: begin
        i_d = '0;
        j_d = '0;
        t_d = '0;
        if (e_q == '0) begin
          mode_d = lrmp_pkg::MD_DOT;
        end else if (e_q[0]) begin
          mode_d = lrmp_pkg::MD_PB;
        end else begin
          e_d    = e_q >> 1;
          mode_d = lrmp_pkg::MD_SQ;
        end
      end
      lrmp_pkg::ST_PROD: begin
        tag_d.valid = 1'b1;
        tag_d.first = (t_q == '0);
        tag_d.last  = (t_q == km1);
        tag_d.fin   = (t_q == km1) && j_last && i_last;
        tag_d.addr  = {i_q, j_q};
        if (t_q == km1) begin
          t_d = '0;
          if (j_last) begin
            j_d = '0;
            i_d = i_last ? '0 : i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          t_d = t_q + 1'b1;
        end
      end
      lrmp_pkg::ST_DRAIN: begin
        if (mac_res.valid && mac_res.fin) begin
          result_d = mac_val;
        end
        i_d = '0;
        j_d = '0;
      end
      lrmp_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = result_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrmp_pkg::ST_IDLE;
      mode_q      <= lrmp_pkg::MD_PB;
      order_q     <= lrmp_pkg::ORDER_W'(1);
      out_valid_q <= 1'b0;
      tag_q       <= '0;
      bld_v_q     <= 1'b0;
      cpy_v_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      t_q         <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      tag_q       <= tag_d;
      bld_v_q     <= bld_v_d;
      cpy_v_q     <= cpy_v_d;
      i_q         <= i_d;
      j_q         <= j_d;
      t_q         <= t_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    e_q        <= e_d;
    result_q   <= result_d;
    out_data_q <= out_data_d;
    bld_addr_q <= bld_addr_d;
    bld_last_q <= bld_last_d;
    bld_sup_q  <= bld_sup_d;
    bld_diag_q <= bld_diag_d;
    cpy_addr_q <= cpy_addr_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.term_value = out_data_q;

  // Memory ports.
  assign coef_raddr  = km1 - j_q;
  assign init_raddr  = (state_q == lrmp_pkg::ST_IDLE) ? (in_i.term_index[IW-1:0] - 1'b1) : t_q;
  assign base_we     = bld_v_q || (cpy_v_q && mode_q == lrmp_pkg::MD_SQ);
  assign power_we    = bld_v_q || (cpy_v_q && mode_q == lrmp_pkg::MD_PB);
  assign mat_waddr   = bld_v_q ? bld_addr_q : cpy_addr_q;
  assign base_wdata  = bld_v_q ? (bld_last_q ? coef_rd : VW'(bld_sup_q)) : scratch_rd;
  assign power_wdata = bld_v_q ? VW'(bld_diag_q) : scratch_rd;
  assign scratch_we  = mac_res.valid && (mode_q != lrmp_pkg::MD_DOT);

  lrmp_ram #(.Width(VW), .Depth(lrmp_pkg::MAX_ORDER)) u_coef (
    .clk_i, .we_i(coef_we), .waddr_i(in_i.slot), .wdata_i(load_val),
    .raddr_i(coef_raddr), .rdata_o(coef_rd)
  );

  lrmp_ram #(.Width(VW), .Depth(lrmp_pkg::MAX_ORDER)) u_init (
    .clk_i, .we_i(init_we), .waddr_i(in_i.slot), .wdata_i(load_val),
    .raddr_i(init_raddr), .rdata_o(init_rd)
  );

  // Two copies of the base matrix give the row and the column read of a square.
  lrmp_ram #(.Width(VW), .Depth(lrmp_pkg::CELLS)) u_base_a (
    .clk_i, .we_i(base_we), .waddr_i(mat_waddr), .wdata_i(base_wdata),
    .raddr_i({i_q, t_q}), .rdata_o(basea_rd)
  );

  lrmp_ram #(.Width(VW), .Depth(lrmp_pkg::CELLS)) u_base_b (
    .clk_i, .we_i(base_we), .waddr_i(mat_waddr), .wdata_i(base_wdata),
    .raddr_i({t_q, j_q}), .rdata_o(baseb_rd)
  );

  lrmp_ram #(.Width(VW), .Depth(lrmp_pkg::CELLS)) u_power (
    .clk_i, .we_i(power_we), .waddr_i(mat_waddr), .wdata_i(power_wdata),
    .raddr_i({i_q, t_q}), .rdata_o(power_rd)
  );

  lrmp_ram #(.Width(VW), .Depth(lrmp_pkg::CELLS)) u_scratch (
    .clk_i, .we_i(scratch_we), .waddr_i(mac_res.addr), .wdata_i(mac_val),
    .raddr_i({i_q, j_q}), .rdata_o(scratch_rd)
  );

  assign mac_a = (mode_q == lrmp_pkg::MD_SQ)  ? basea_rd : power_rd;
  assign mac_b = (mode_q == lrmp_pkg::MD_DOT) ? init_rd  : baseb_rd;

  lrmp_mac u_mac (
    .clk_i, .rst_ni, .tag_i(tag_q), .a_i(mac_a), .b_i(mac_b),
    .res_o(mac_res), .value_o(mac_val)
  );

  `LRMP_ASSERT_IMPLY(a_res_in_prod, mac_res.valid, mac_phase)
  `LRMP_ASSERT_IMPLY(a_wr_exclusive, bld_v_q, !cpy_v_q)
  `LRMP_ASSERT_NEXT(a_done_loads, (state_q == lrmp_pkg::ST_DONE && !out_valid_q), out_o.valid)

endmodule

// ===== rtl/lrmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrmp_ram #(
  parameter int Width = 30,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrmp_mac.sv =====
// Pipelined modular multiply-accumulate unit (Barrett reduction mod 1e9).
module lrmp_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lrmp_pkg::mac_tag_t             tag_i,
  input  logic [lrmp_pkg::VAL_W-1:0]     a_i,
  input  logic [lrmp_pkg::VAL_W-1:0]     b_i,
  output lrmp_pkg::mac_tag_t             res_o,
  output logic [lrmp_pkg::VAL_W-1:0]     value_o
);

  lrmp_pkg::mac_tag_t tag1_q, tag2_q, tag3_q, tag4_q, tag5_q, res_q;
  logic [59:0] p1_q;
  logic [61:0] t2_q;
  logic [31:0] lo2_q, lo3_q, qm3_q, r4_q;
  logic [lrmp_pkg::VAL_W-1:0] r5_d, r5_q, acc_d, acc_q;
  logic [60:0] qm_full;
  logic [lrmp_pkg::VAL_W:0] sum;
  lrmp_pkg::mac_tag_t res_d;

  localparam logic [31:0] MOD32 = 32'(lrmp_pkg::MODULUS);
  localparam logic [31:0] MOD2X = 32'(2 * 64'(lrmp_pkg::MODULUS));

  always_comb begin
    qm_full = 61'(t2_q[61:31]) * 61'(lrmp_pkg::MODULUS);
    // Barrett estimate is low by at most two moduli
    if (r4_q >= MOD2X) begin
      r5_d = lrmp_pkg::VAL_W'(r4_q - MOD2X);
    end else if (r4_q >= MOD32) begin
      r5_d = lrmp_pkg::VAL_W'(r4_q - MOD32);
    end else begin
      r5_d = lrmp_pkg::VAL_W'(r4_q);
    end
    sum = (tag5_q.first ? '0 : {1'b0, acc_q}) + {1'b0, r5_q};
    if (sum >= {1'b0, lrmp_pkg::MODULUS}) begin
      acc_d = lrmp_pkg::VAL_W'(sum - {1'b0, lrmp_pkg::MODULUS});
    end else begin
      acc_d = sum[lrmp_pkg::VAL_W-1:0];
    end
    res_d       = tag5_q;
    res_d.valid = tag5_q.valid && tag5_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
      res_q  <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      tag5_q <= tag4_q;
      res_q  <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= 60'(a_i) * 60'(b_i);
    t2_q  <= 62'(p1_q[59:29]) * 62'(lrmp_pkg::BARRETT_MU);
    lo2_q <= p1_q[31:0];
    lo3_q <= lo2_q;
    qm3_q <= qm_full[31:0];
    r4_q  <= lo3_q - qm3_q;
    r5_q  <= r5_d;
    if (tag5_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign res_o   = res_q;
  assign value_o = acc_q;

endmodule

// ===== verif/linear_recurrence_matrix_power_tb.sv =====
// Self-checking testbench for the linear recurrence matrix power block.
module linear_recurrence_matrix_power_tb;

  localparam int IDX_W     = lrmp_pkg::IDX_W;
  localparam int VAL_W     = lrmp_pkg::VAL_W;
  localparam int N_W       = lrmp_pkg::N_W;
  localparam int ORDER_W   = lrmp_pkg::ORDER_W;
  localparam int MAX_ORDER = lrmp_pkg::MAX_ORDER;
  localparam logic [VAL_W-1:0] MODULUS = lrmp_pkg::MODULUS;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         WATCH_LIMIT = 2000000;
  localparam int         HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] slot;
    logic [VAL_W-1:0] load_value;
    logic [N_W-1:0]   term_index;
  } word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ORDER_W-1:0] cfg_wdata_i;

  lrmp_in_if  in_i ();
  lrmp_out_if out_o ();

  linear_recurrence_matrix_power dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i.sink),
    .out_o       (out_o.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predictor state
  logic [ORDER_W-1:0] order_q;
  logic [VAL_W-1:0]   coef_mem [MAX_ORDER];
  logic [VAL_W-1:0]   init_mem [MAX_ORDER];
  logic [VAL_W-1:0]   term_expected_q [$];
  word_t              word_pending_q [$];

  int  error_count;
  int  watch_count;
  bit  calm;
  bit  sink_hold;
  bit  hold_start;
  int  in_idle_pct;

  function automatic logic [VAL_W-1:0] mod_mac(logic [VAL_W-1:0] acc,
                                               logic [VAL_W-1:0] a,
                                               logic [VAL_W-1:0] b);
    logic [63:0] p;
    logic [63:0] s;
    p = 64'(a) * 64'(b);
    s = 64'(acc) + (p % 64'(MODULUS));
    return VAL_W'(s % 64'(MODULUS));
  endfunction

  typedef logic [VAL_W-1:0] mat_t [MAX_ORDER][MAX_ORDER];

  function automatic mat_t mat_product(mat_t x, mat_t y, int k);
    mat_t r;
    logic [VAL_W-1:0] acc;
    r = x;
    for (int i = 0; i < k; i++)
      for (int j = 0; j < k; j++) begin
        acc = '0;
        for (int t = 0; t < k; t++) acc = mod_mac(acc, x[i][t], y[t][j]);
        r[i][j] = acc;
      end
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] term_of(logic [N_W-1:0] n);
    int k;
    mat_t basem;
    mat_t pw;
    logic [N_W-1:0] e;
    logic [VAL_W-1:0] acc;
    k = (order_q < 1) ? 1 : (order_q > MAX_ORDER) ? MAX_ORDER : int'(order_q);
    if (n == 0) return '0;
    if (n <= N_W'(k)) return init_mem[n - 1];
    for (int i = 0; i < MAX_ORDER; i++)
      for (int j = 0; j < MAX_ORDER; j++) begin
        basem[i][j] = '0;
        pw[i][j] = (i == j) ? VAL_W'(1) : '0;
      end
    for (int i = 0; i + 1 < k; i++) basem[i][i+1] = VAL_W'(1);
    for (int j = 0; j < k; j++) basem[k-1][j] = coef_mem[k-1-j];
    e = n - 1;
    while (e != 0) begin
      if (e[0]) pw = mat_product(pw, basem, k);
      e = e >> 1;
      if (e != 0) basem = mat_product(basem, basem, k);
    end
    acc = '0;
    for (int j = 0; j < k; j++) acc = mod_mac(acc, pw[0][j], init_mem[j]);
    return acc;
  endfunction

  task automatic apply_word(word_t w);
    logic [VAL_W-1:0] v;
    v = (w.load_value >= MODULUS) ? w.load_value - MODULUS : w.load_value;
    case (w.command)
      lrmp_pkg::CMD_LOAD_COEF: coef_mem[w.slot] = v;
      lrmp_pkg::CMD_LOAD_INIT: init_mem[w.slot] = v;
      lrmp_pkg::CMD_QUERY:
        term_expected_q.insert(term_expected_q.size(), term_of(w.term_index));
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic queue_word(word_t w);
    word_pending_q.insert(word_pending_q.size(), w);
  endtask

  // Driver: offer queued words, idle at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        apply_word(word_t'({in_i.command, in_i.slot, in_i.load_value, in_i.term_index}));
        void'(word_pending_q.pop_front());
      end
      if (!in_i.valid || in_i.ready) begin
        if (word_pending_q.size() > 0 &&
            (calm || $urandom_range(99) >= in_idle_pct)) begin
          in_i.valid      <= 1'b1;
          in_i.command    <= word_pending_q[0].command;
          in_i.slot       <= word_pending_q[0].slot;
          in_i.load_value <= word_pending_q[0].load_value;
          in_i.term_index <= word_pending_q[0].term_index;
        end else begin
          in_i.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: accept result words, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
      watch_count <= 0;
    end else begin
      if (out_o.valid && out_o.ready) begin
        if (term_expected_q.size() == 0) report_mismatch("result word with none expected");
        else begin
          if (out_o.term_value !== term_expected_q[0])
            report_mismatch($sformatf("term_value got %0d want %0d",
                                      out_o.term_value, term_expected_q[0]));
          void'(term_expected_q.pop_front());
        end
      end
      out_o.ready <= !sink_hold && (calm || $urandom_range(99) >= 13);
      if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) watch_count <= 0;
      else watch_count <= watch_count + 1;
      if (watch_count >= WATCH_LIMIT) begin
        $display("linear_recurrence_matrix_power_tb: done, errors");
        $finish;
      end
    end
  end

  // Receiver hold: count the long stretch here once it is requested.
  initial begin
    sink_hold = 1'b0;
    wait (hold_start);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  function automatic word_t make_word(logic [1:0] c, int s, logic [VAL_W-1:0] v,
                                      logic [N_W-1:0] n);
    word_t w;
    w.command = c;
    w.slot = IDX_W'(s);
    w.load_value = v;
    w.term_index = n;
    return w;
  endfunction

  // Load every slot so no query reads an unwritten entry.
  task automatic queue_fill();
    for (int s = 0; s < MAX_ORDER; s++) begin
      queue_word(make_word(lrmp_pkg::CMD_LOAD_COEF, s, VAL_W'($urandom), '0));
      queue_word(make_word(lrmp_pkg::CMD_LOAD_INIT, s, VAL_W'($urandom), '0));
    end
  endtask

  function automatic logic [N_W-1:0] random_n(int k);
    case ($urandom_range(9))
      0, 1, 2: return N_W'($urandom_range(k + 1));
      3:       return N_W'({$urandom, $urandom} >> 1);
      default: return N_W'($urandom_range(200, k + 2));
    endcase
  endfunction

  task automatic wait_drained();
    while (word_pending_q.size() != 0 || in_i.valid || term_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_order(logic [ORDER_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    order_q = v;
  endtask

  initial begin
    int k;
    logic [ORDER_W-1:0] orders [6];
    error_count = 0;
    calm = 1'b0;
    hold_start = 1'b0;
    in_idle_pct = 13;
    order_q = ORDER_W'(1);
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_i.command = '0;
    in_i.slot = '0;
    in_i.load_value = '0;
    in_i.term_index = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command, oversized values, unused command
    queue_fill();
    queue_word(make_word(lrmp_pkg::CMD_LOAD_COEF, 0, 30'h3FFF_FFFF, '0));
    queue_word(make_word(lrmp_pkg::CMD_LOAD_INIT, 0, MODULUS, '0));
    queue_word(make_word(lrmp_pkg::CMD_LOAD_INIT, 15, MODULUS - 1, '0));
    queue_word(make_word(CMD_UNUSED, 5, 30'h3FFF_FFFF, '1));
    queue_word(make_word(lrmp_pkg::CMD_QUERY, 0, '0, '0));
    queue_word(make_word(lrmp_pkg::CMD_QUERY, 15, 30'h3FFF_FFFF, 1));
    queue_word(make_word(lrmp_pkg::CMD_QUERY, 0, '0, 2));
    queue_word(make_word(lrmp_pkg::CMD_QUERY, 0, '0, '1));
    wait_drained();

    orders = '{ORDER_W'(0), ORDER_W'(16), ORDER_W'(31), ORDER_W'(2), ORDER_W'(5), ORDER_W'(1)};
    foreach (orders[p]) begin
      write_order(orders[p]);
      k = (orders[p] < 1) ? 1 : (orders[p] > MAX_ORDER) ? MAX_ORDER : int'(orders[p]);
      calm = (p == 3);
      // Hold the receiver off while short queries keep coming.
      if (p == 4) begin
        for (int i = 0; i < 6; i++)
          queue_word(make_word(lrmp_pkg::CMD_QUERY, 0, '0, N_W'($urandom_range(k))));
        hold_start = 1'b1;
      end
      for (int i = 0; i < 10; i++) begin
        case ($urandom_range(5))
          0: queue_word(make_word(lrmp_pkg::CMD_LOAD_COEF, $urandom_range(15),
                                  VAL_W'($urandom), N_W'({$urandom, $urandom})));
          1: queue_word(make_word(lrmp_pkg::CMD_LOAD_INIT, $urandom_range(15),
                                  VAL_W'($urandom), N_W'({$urandom, $urandom})));
          2: queue_word(make_word(CMD_UNUSED, $urandom_range(15),
                                  VAL_W'($urandom), N_W'({$urandom, $urandom})));
          default: queue_word(make_word(lrmp_pkg::CMD_QUERY, $urandom_range(15),
                                        VAL_W'($urandom), random_n(k)));
        endcase
      end
      wait_drained();
    end

    if (error_count == 0) $display("linear_recurrence_matrix_power_tb: done, clean");
    else $display("linear_recurrence_matrix_power_tb: done, errors");
    $finish;
  end
endmodule
